### src/steq_pkg.sv
// package for the sorted tick event queue
// types, opcodes, status codes and sizes; no dependencies
`timescale 1ns / 1ps
package steq_pkg;

    localparam int QueueDepthDef   = 32;
    localparam int TickBitsDef     = 48;
    localparam int KindBitsDef     = 16;
    localparam int ListenerBitsDef = 8;
    localparam int FireLimit       = 32;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_SUB     = 3'd1,
        OP_REM_EX  = 3'd2,
        OP_REM_LK  = 3'd3,
        OP_REM_L   = 3'd4,
        OP_QUERY   = 3'd5,
        OP_NOP6    = 3'd6,
        OP_NOP7    = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        RK_FIRED  = 2'd0,
        RK_EMPTY  = 2'd1,
        RK_STATUS = 2'd2,
        RK_RSVD   = 2'd3
    } rkind_t;

    typedef enum logic [2:0] {
        ST_DONE  = 3'd0,
        ST_DUP   = 3'd1,
        ST_NONE  = 3'd2,
        ST_FULL  = 3'd3,
        ST_RANGE = 3'd4
    } status_t;

    typedef struct packed {
        logic [2:0]                 opcode;
        logic [ListenerBitsDef-1:0] listener_id;
        logic [31:0]                idle_ticks;
        logic [KindBitsDef-1:0]     event_kind;
        logic [TickBitsDef-1:0]     target_tick;
    } cmd_t;

    typedef struct packed {
        logic [1:0]                 result_kind;
        logic [ListenerBitsDef-1:0] fired_listener;
        logic [TickBitsDef-1:0]     fired_tick;
        logic [KindBitsDef-1:0]     fired_kind;
        logic [2:0]                 status;
        logic [5:0]                 removed_count;
        logic                       last;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE,
        S_DONE
    } state_t;

    // port into the entry memory
    typedef struct packed {
        logic       rd_en;
        logic [5:0] rd_addr;
        logic       wr_en;
        logic [5:0] wr_addr;
    } mem_ctl_t;

endpackage

### src/sorted_tick_event_queue_unit.sv
// Sorted tick event queue, top level.
// Command port: an item on cmd is taken at a clock edge with start high and
// busy low. Results leave on res, one per cycle of res_valid; the receiver
// cannot stall them, and the final result of an item has last set.
// Tick: count goes up by one (holding at all ones), then due head entries pop
// and are reported in queue order, at most 32 per tick, else one empty result.
// Subscribe inserts in order of (tick, kind, listener); removes compact the
// queue; query reports presence; other opcodes give one status result.
// Entries sit in one memory with a registered read. Each walk step is a
// read and then a use of the data, so a read never meets a write to the
// same entry.
// Reset clears the entry count, tick count and result strobe; the entry
// memory keeps stale data, and only entries below the count are read.
// depends on steq_pkg, steq_mem
`timescale 1ns / 1ps
module sorted_tick_event_queue_unit
    import steq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDef
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    output logic busy,
    output logic res_valid,
    output res_t res
);
    localparam int TICK_BITS     = TickBitsDef;
    localparam int KIND_BITS     = KindBitsDef;
    localparam int LISTENER_BITS = ListenerBitsDef;
    localparam int EW = TICK_BITS + KIND_BITS + LISTENER_BITS;
    localparam logic [TICK_BITS-1:0] TMAX = '1;
    localparam logic [TICK_BITS-1:0] TONE = {{(TICK_BITS-1){1'b0}}, 1'b1};
    localparam logic [6:0] DEPTH7 = 7'(QUEUE_DEPTH);

    typedef struct packed {
        logic [TICK_BITS-1:0]     t;
        logic [KIND_BITS-1:0]     k;
        logic [LISTENER_BITS-1:0] l;
    } ent_t;

    // index walk: rd pointer r, wr pointer w, both over 0..count
    state_t state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [TICK_BITS-1:0] tick_reg, tick_next;
    logic [6:0] r_reg, r_next, w_reg, w_next;
    logic       phase_reg, phase_next;     // 0 issue read, 1 data back
    logic [2:0] op_reg, op_next;
    ent_t       key_reg, key_next;         // compare key / item to insert
    ent_t       hold_reg, hold_next;       // fired entry waiting for its last flag
    logic [6:0] nrem_reg, nrem_next;
    logic [6:0] fired_reg, fired_next;
    logic       res_v_reg, res_v_next;
    res_t       res_reg, res_next;
    logic       scan_end;

    mem_ctl_t ctl;
    ent_t     wdata, rdata;

    steq_mem #(.DEPTH(QUEUE_DEPTH), .WIDTH(EW)) u_mem (
        .clk   (clk),
        .ctl   (ctl),
        .wdata (wdata),
        .rdata (rdata)
    );

    logic [TICK_BITS:0] sum;
    assign sum = {1'b0, tick_reg} + (TICK_BITS+1)'(cmd.idle_ticks);

    // order compare of key against read entry
    logic key_gt, key_eq, hit;
    assign key_eq = (key_reg == rdata);
    assign key_gt = (key_reg > rdata);
    assign hit = (rdata.l == key_reg.l) &&
                 ((op_reg == OP_REM_L) || (rdata.k == key_reg.k));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            tick_reg  <= '0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            tick_reg  <= tick_next;
            res_v_reg <= res_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg     <= r_next;
        w_reg     <= w_next;
        phase_reg <= phase_next;
        op_reg    <= op_next;
        key_reg   <= key_next;
        hold_reg  <= hold_next;
        nrem_reg  <= nrem_next;
        fired_reg <= fired_next;
        res_reg   <= res_next;
    end

    function automatic res_t stat(input logic [2:0] st, input logic [5:0] n);
        res_t x;
        x = '0;
        x.result_kind = RK_STATUS;
        x.status = st;
        x.removed_count = n;
        x.last = 1'b1;
        return x;
    endfunction

    function automatic res_t fire(input ent_t e, input logic lst);
        res_t x;
        x = '0;
        x.result_kind = RK_FIRED;
        x.fired_listener = e.l;
        x.fired_tick = e.t;
        x.fired_kind = e.k;
        x.last = lst;
        return x;
    endfunction

    // next state and datapath
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        tick_next  = tick_reg;
        r_next     = r_reg;
        w_next     = w_reg;
        phase_next = phase_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        hold_next  = hold_reg;
        nrem_next  = nrem_reg;
        fired_next = fired_reg;
        res_v_next = 1'b0;
        res_next   = res_reg;
        ctl        = '0;
        wdata      = hold_reg;
        scan_end   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start && !res_v_reg)
                begin
                    op_next    = cmd.opcode;
                    r_next     = '0;
                    w_next     = '0;
                    phase_next = 1'b0;
                    nrem_next  = '0;
                    fired_next = '0;
                    key_next.k = cmd.event_kind;
                    key_next.l = cmd.listener_id;
                    key_next.t = cmd.target_tick;
                    state_next = S_SCAN;
                    case (cmd.opcode)
                        OP_TICK:
                        begin
                            if (tick_reg != TMAX)
                            begin
                                tick_next = tick_reg + TONE;
                            end
                        end
                        OP_SUB:
                        begin
                            key_next.t = sum[TICK_BITS-1:0];
                            if (sum[TICK_BITS])
                            begin
                                res_next   = stat(ST_RANGE, '0);
                                state_next = S_DONE;
                            end
                        end
                        OP_REM_EX, OP_REM_LK, OP_REM_L, OP_QUERY:
                        begin
                            // search starts at the head
                        end
                        default:
                        begin
                            res_next   = stat(ST_DONE, '0);
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!phase_reg)
                begin
                    if (r_reg < cnt_reg &&
                        (op_reg != OP_TICK || fired_reg < 7'(FireLimit)))
                    begin
                        ctl.rd_en   = 1'b1;
                        ctl.rd_addr = 6'(r_reg);
                        phase_next  = 1'b1;
                    end
                    else
                    begin
                        scan_end = 1'b1;
                    end
                end
                else
                begin
                    phase_next = 1'b0;
                    case (op_reg)
                        OP_TICK:
                        begin
                            // due head entry: report the one held before it
                            if (rdata.t <= tick_reg)
                            begin
                                if (fired_reg != '0)
                                begin
                                    res_next   = fire(hold_reg, 1'b0);
                                    res_v_next = 1'b1;
                                end
                                hold_next  = rdata;
                                fired_next = fired_reg + 7'd1;
                                r_next     = r_reg + 7'd1;
                            end
                            else
                            begin
                                scan_end = 1'b1;
                            end
                        end
                        OP_SUB:
                        begin
                            if (key_eq)
                            begin
                                res_next   = stat(ST_DUP, '0);
                                state_next = S_DONE;
                            end
                            else if (key_gt)
                            begin
                                r_next = r_reg + 7'd1;
                            end
                            else
                            begin
                                scan_end = 1'b1;
                            end
                        end
                        OP_REM_EX, OP_QUERY:
                        begin
                            if (key_eq)
                            begin
                                if (op_reg == OP_QUERY)
                                begin
                                    res_next   = stat(ST_DONE, '0);
                                    state_next = S_DONE;
                                end
                                else
                                begin
                                    w_next     = r_reg;
                                    r_next     = r_reg + 7'd1;
                                    state_next = S_MOVE;
                                end
                            end
                            else if (key_gt)
                            begin
                                r_next = r_reg + 7'd1;
                            end
                            else
                            begin
                                scan_end = 1'b1;
                            end
                        end
                        default:
                        begin
                            // listener removes: keep non-matching entries packed at w
                            if (hit)
                            begin
                                nrem_next = nrem_reg + 7'd1;
                            end
                            else
                            begin
                                ctl.wr_en   = 1'b1;
                                ctl.wr_addr = 6'(w_reg);
                                wdata       = rdata;
                                w_next      = w_reg + 7'd1;
                            end
                            r_next = r_reg + 7'd1;
                        end
                    endcase
                end
                // end of the search walk
                if (scan_end)
                begin
                    case (op_reg)
                        OP_TICK:
                        begin
                            res_v_next = 1'b1;
                            if (fired_reg != '0)
                            begin
                                res_next   = fire(hold_reg, 1'b1);
                                w_next     = '0;
                                state_next = S_MOVE;
                            end
                            else
                            begin
                                res_next = '0;
                                res_next.result_kind = RK_EMPTY;
                                res_next.fired_tick  = tick_reg;
                                res_next.last        = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        OP_SUB:
                        begin
                            if (cnt_reg >= DEPTH7)
                            begin
                                res_next   = stat(ST_FULL, '0);
                                state_next = S_DONE;
                            end
                            else
                            begin
                                w_next     = r_reg;
                                r_next     = cnt_reg;
                                state_next = S_MOVE;
                            end
                        end
                        OP_REM_EX, OP_QUERY:
                        begin
                            res_next   = stat(ST_NONE, '0);
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            cnt_next   = w_reg;
                            res_next   = stat((nrem_reg != '0) ? ST_DONE : ST_NONE,
                                              6'(nrem_reg));
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_MOVE:
            begin
                if (op_reg == OP_SUB)
                begin
                    // shift up from the top: entry r-1 moves to r, key lands at w
                    if (!phase_reg)
                    begin
                        if (r_reg > w_reg)
                        begin
                            ctl.rd_en   = 1'b1;
                            ctl.rd_addr = 6'(r_reg - 7'd1);
                            phase_next  = 1'b1;
                        end
                        else
                        begin
                            ctl.wr_en   = 1'b1;
                            ctl.wr_addr = 6'(w_reg);
                            wdata       = key_reg;
                            cnt_next    = cnt_reg + 7'd1;
                            res_next    = stat(ST_DONE, '0);
                            state_next  = S_DONE;
                        end
                    end
                    else
                    begin
                        ctl.wr_en   = 1'b1;
                        ctl.wr_addr = 6'(r_reg);
                        wdata       = rdata;
                        r_next      = r_reg - 7'd1;
                        phase_next  = 1'b0;
                    end
                end
                else
                begin
                    // shift down: entry r moves to w
                    if (!phase_reg)
                    begin
                        if (r_reg < cnt_reg)
                        begin
                            ctl.rd_en   = 1'b1;
                            ctl.rd_addr = 6'(r_reg);
                            phase_next  = 1'b1;
                        end
                        else
                        begin
                            cnt_next = w_reg;
                            if (op_reg == OP_TICK)
                            begin
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                res_next   = stat(ST_DONE, 6'd1);
                                state_next = S_DONE;
                            end
                        end
                    end
                    else
                    begin
                        ctl.wr_en   = 1'b1;
                        ctl.wr_addr = 6'(w_reg);
                        wdata       = rdata;
                        r_next      = r_reg + 7'd1;
                        w_next      = w_reg + 7'd1;
                        phase_next  = 1'b0;
                    end
                end
            end
            S_DONE:
            begin
                res_v_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy      = (state_reg != S_IDLE) || res_v_reg;
        res_valid = res_v_reg;
        res       = res_reg;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH7)
        else $error("entry count above depth");
    a_busy_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted without busy");
    a_tick_mono: assert property (@(posedge clk) disable iff (!rst_n)
        tick_reg >= $past(tick_reg))
        else $error("tick counter went back");
`endif
endmodule

### src/steq_mem.sv
// entry memory: one write and one registered read port
// uses steq_pkg for the control struct
`timescale 1ns / 1ps
module steq_mem
    import steq_pkg::*;
#(
    parameter int DEPTH = QueueDepthDef,
    parameter int WIDTH = 72
)
(
    input  logic             clk,
    input  mem_ctl_t         ctl,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr[AW-1:0]] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata <= mem[ctl.rd_addr[AW-1:0]];
        end
    end
endmodule
